### rtl/bilin_pkg.sv
// shared constants, types and codes for the bilinear rgba sampler
package bilin_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int NUM_CHAN = 4;
  localparam int CHAN_W   = 16;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int IN_COL_W = 8;
  localparam int IN_ROW_W = 8;
  localparam int DIM_W    = 9;
  localparam int COORD_W  = 17;
  localparam int HI_W     = DIM_W + FRAC_BITS;
  localparam int WGT_W    = FRAC_BITS + 1;
  localparam int ONE_FIX  = 1 << FRAC_BITS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // four banks split by row and column parity
  localparam int NUM_BANKS  = 4;
  localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);

  // channel 0 is red, 1 green, 2 blue, 3 alpha
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] texel_t;

  typedef struct packed {
    logic                 is_write;
    logic                 wr_en;
    logic [COL_W-1:0]     wr_col;
    logic [ROW_W-1:0]     wr_row;
    texel_t               texel;
    logic [COL_W-1:0]     x0;
    logic [COL_W-1:0]     x1;
    logic [ROW_W-1:0]     y0;
    logic [ROW_W-1:0]     y1;
    logic [FRAC_BITS-1:0] tx;
    logic [FRAC_BITS-1:0] ty;
    logic                 empty;
  } qent_t;

endpackage

### rtl/bilin_front.sv
// front end: config registers, input acceptance, coordinate clamp and neighbour indices
module bilin_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bilin_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bilin_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_kind,
  input  logic [bilin_pkg::IN_COL_W-1:0]         in_texel_col,
  input  logic [bilin_pkg::IN_ROW_W-1:0]         in_texel_row,
  input  logic [bilin_pkg::CHAN_W-1:0]           in_write_red,
  input  logic [bilin_pkg::CHAN_W-1:0]           in_write_green,
  input  logic [bilin_pkg::CHAN_W-1:0]           in_write_blue,
  input  logic [bilin_pkg::CHAN_W-1:0]           in_write_alpha,
  input  logic signed [bilin_pkg::COORD_W-1:0]   in_sample_x,
  input  logic signed [bilin_pkg::COORD_W-1:0]   in_sample_y,
  output logic                                   push_valid,
  input  logic                                   push_ready,
  output bilin_pkg::qent_t                       push_entry
);

  logic [bilin_pkg::CFG_DATA_W-1:0] width_r, width_nxt;
  logic [bilin_pkg::CFG_DATA_W-1:0] height_r, height_nxt;
  logic                             fv_r, fv_nxt;
  bilin_pkg::qent_t                 entry_r, entry_nxt;
  logic [bilin_pkg::DIM_W-1:0]      w_eff, h_eff;
  logic [bilin_pkg::HI_W-1:0]       cx, cy;
  logic [bilin_pkg::DIM_W-1:0]      x_nxt1, y_nxt1;
  logic                             accept;

  function automatic logic [bilin_pkg::HI_W-1:0] clamp_coord(
    logic signed [bilin_pkg::COORD_W-1:0] c,
    logic [bilin_pkg::DIM_W-1:0]          dim
  );
    logic [bilin_pkg::HI_W-1:0] hi;
    logic [bilin_pkg::HI_W-1:0] mag;
    hi  = bilin_pkg::HI_W'(dim - bilin_pkg::DIM_W'(1)) << bilin_pkg::FRAC_BITS;
    mag = bilin_pkg::HI_W'(c[bilin_pkg::COORD_W-2:0]);
    if (c[bilin_pkg::COORD_W-1]) begin
      return '0;
    end else if (mag > hi) begin
      return hi;
    end else begin
      return mag;
    end
  endfunction

  assign cfg_ready  = 1'b1;
  assign in_ready   = !fv_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = fv_r;
  assign push_entry = entry_r;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bilin_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        bilin_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (width_r > bilin_pkg::DIM_W'(bilin_pkg::MAX_WIDTH)) ?
            bilin_pkg::DIM_W'(bilin_pkg::MAX_WIDTH) : bilin_pkg::DIM_W'(width_r);
    h_eff = (height_r > bilin_pkg::DIM_W'(bilin_pkg::MAX_HEIGHT)) ?
            bilin_pkg::DIM_W'(bilin_pkg::MAX_HEIGHT) : bilin_pkg::DIM_W'(height_r);
    cx = clamp_coord(in_sample_x, w_eff);
    cy = clamp_coord(in_sample_y, h_eff);

    entry_nxt          = entry_r;
    entry_nxt.is_write = (in_kind == bilin_pkg::KIND_WRITE);
    entry_nxt.wr_en    = (32'(in_texel_col) < bilin_pkg::MAX_WIDTH) &&
                         (32'(in_texel_row) < bilin_pkg::MAX_HEIGHT);
    entry_nxt.wr_col   = bilin_pkg::COL_W'(in_texel_col);
    entry_nxt.wr_row   = bilin_pkg::ROW_W'(in_texel_row);
    entry_nxt.texel    = {in_write_alpha, in_write_blue, in_write_green, in_write_red};
    entry_nxt.x0       = cx[bilin_pkg::FRAC_BITS +: bilin_pkg::COL_W];
    entry_nxt.y0       = cy[bilin_pkg::FRAC_BITS +: bilin_pkg::ROW_W];
    entry_nxt.tx       = cx[bilin_pkg::FRAC_BITS-1:0];
    entry_nxt.ty       = cy[bilin_pkg::FRAC_BITS-1:0];
    // right and lower neighbours stick to the last column and row
    x_nxt1 = bilin_pkg::DIM_W'(entry_nxt.x0) + bilin_pkg::DIM_W'(1);
    y_nxt1 = bilin_pkg::DIM_W'(entry_nxt.y0) + bilin_pkg::DIM_W'(1);
    entry_nxt.x1 = (x_nxt1 < w_eff) ? x_nxt1[bilin_pkg::COL_W-1:0] :
                   bilin_pkg::COL_W'(w_eff - bilin_pkg::DIM_W'(1));
    entry_nxt.y1 = (y_nxt1 < h_eff) ? y_nxt1[bilin_pkg::ROW_W-1:0] :
                   bilin_pkg::ROW_W'(h_eff - bilin_pkg::DIM_W'(1));
    entry_nxt.empty = (w_eff == '0) || (h_eff == '0);

    fv_nxt = fv_r;
    if (accept) begin
      fv_nxt = 1'b1;
    end else if (push_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      fv_r     <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      fv_r     <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

### rtl/bilin_queue.sv
// short fifo of classified transactions between front and back
module bilin_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  bilin_pkg::qent_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output bilin_pkg::qent_t pop_entry
);

  bilin_pkg::qent_t                slot_r [bilin_pkg::QUEUE_DEPTH];
  logic [bilin_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [bilin_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [bilin_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                            do_push, do_pop;

  assign push_ready = (count_r != bilin_pkg::QCNT_W'(bilin_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + bilin_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + bilin_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + bilin_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - bilin_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/bilin_back.sv
// back end: banked texel store, neighbour fetch and two-step bilinear blend
module bilin_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  bilin_pkg::qent_t              pop_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bilin_pkg::CHAN_W-1:0]  out_red,
  output logic [bilin_pkg::CHAN_W-1:0]  out_green,
  output logic [bilin_pkg::CHAN_W-1:0]  out_blue,
  output logic [bilin_pkg::CHAN_W-1:0]  out_alpha
);

  localparam int TOP_W  = bilin_pkg::CHAN_W + bilin_pkg::FRAC_BITS;
  localparam int PROD_W = TOP_W + 1;
  localparam int SUMX_W = TOP_W + bilin_pkg::WGT_W;
  localparam int SHIFT  = 2 * bilin_pkg::FRAC_BITS;
  localparam logic [SUMX_W-1:0] RND = SUMX_W'(1) << (SHIFT - 1);

  logic adv;

  // fetch stage
  logic [bilin_pkg::BANK_AW-1:0]   rd_addr [bilin_pkg::NUM_BANKS];
  bilin_pkg::texel_t               rd_data_r [bilin_pkg::NUM_BANKS];
  logic [bilin_pkg::BANK_AW-1:0]   wr_addr;
  logic [1:0]                      wr_bank;
  logic                            wr_go;
  logic                            s1_valid_r;
  logic                            s1_empty_r;
  logic [bilin_pkg::FRAC_BITS-1:0] s1_tx_r, s1_ty_r;
  logic [1:0]                      s1_i00_r, s1_i10_r, s1_i01_r, s1_i11_r;

  // horizontal blend stage
  logic [bilin_pkg::WGT_W-1:0]     ux, uy;
  bilin_pkg::texel_t               p00, p10, p01, p11;
  logic [TOP_W-1:0]                top_nxt [bilin_pkg::NUM_CHAN];
  logic [TOP_W-1:0]                bot_nxt [bilin_pkg::NUM_CHAN];
  logic [TOP_W-1:0]                top_r [bilin_pkg::NUM_CHAN];
  logic [TOP_W-1:0]                bot_r [bilin_pkg::NUM_CHAN];
  logic                            s2_valid_r;
  logic                            s2_empty_r;
  logic [bilin_pkg::WGT_W-1:0]     s2_uy_r;
  logic [bilin_pkg::FRAC_BITS-1:0] s2_ty_r;

  // vertical blend and result register
  logic [SUMX_W-1:0]               sum [bilin_pkg::NUM_CHAN];
  bilin_pkg::texel_t               res_nxt;
  bilin_pkg::texel_t               res_r;
  logic                            out_valid_r, out_valid_nxt;

  // whole back end advances unless a result is stuck at the output
  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = adv;

  assign wr_addr = {pop_entry.wr_row[bilin_pkg::ROW_W-1:1], pop_entry.wr_col[bilin_pkg::COL_W-1:1]};
  assign wr_bank = {pop_entry.wr_row[0], pop_entry.wr_col[0]};
  assign wr_go   = adv && pop_valid && pop_entry.is_write && pop_entry.wr_en;

  always_comb begin
    logic [bilin_pkg::ROW_W-1:0] rsel;
    logic [bilin_pkg::COL_W-1:0] csel;
    rsel = '0;
    csel = '0;
    for (int b = 0; b < bilin_pkg::NUM_BANKS; b++) begin
      // each parity bank gets whichever neighbour has its parity
      rsel = (pop_entry.y0[0] == b[1]) ? pop_entry.y0 : pop_entry.y1;
      csel = (pop_entry.x0[0] == b[0]) ? pop_entry.x0 : pop_entry.x1;
      rd_addr[b] = {rsel[bilin_pkg::ROW_W-1:1], csel[bilin_pkg::COL_W-1:1]};
    end
  end

  for (genvar b = 0; b < bilin_pkg::NUM_BANKS; b++) begin : g_bank
    bilin_pkg::texel_t mem [bilin_pkg::BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_go && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= pop_entry.texel;
      end
      if (adv) begin
        rd_data_r[b] <= mem[rd_addr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_empty_r <= pop_entry.empty;
      s1_tx_r    <= pop_entry.tx;
      s1_ty_r    <= pop_entry.ty;
      s1_i00_r   <= {pop_entry.y0[0], pop_entry.x0[0]};
      s1_i10_r   <= {pop_entry.y0[0], pop_entry.x1[0]};
      s1_i01_r   <= {pop_entry.y1[0], pop_entry.x0[0]};
      s1_i11_r   <= {pop_entry.y1[0], pop_entry.x1[0]};
    end
  end

  always_comb begin
    ux  = bilin_pkg::WGT_W'(bilin_pkg::ONE_FIX) - bilin_pkg::WGT_W'(s1_tx_r);
    uy  = bilin_pkg::WGT_W'(bilin_pkg::ONE_FIX) - bilin_pkg::WGT_W'(s1_ty_r);
    p00 = rd_data_r[s1_i00_r];
    p10 = rd_data_r[s1_i10_r];
    p01 = rd_data_r[s1_i01_r];
    p11 = rd_data_r[s1_i11_r];
    for (int k = 0; k < bilin_pkg::NUM_CHAN; k++) begin
      top_nxt[k] = TOP_W'(PROD_W'(p00[k]) * PROD_W'(ux) + PROD_W'(p10[k]) * PROD_W'(s1_tx_r));
      bot_nxt[k] = TOP_W'(PROD_W'(p01[k]) * PROD_W'(ux) + PROD_W'(p11[k]) * PROD_W'(s1_tx_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      top_r      <= top_nxt;
      bot_r      <= bot_nxt;
      s2_empty_r <= s1_empty_r;
      s2_uy_r    <= uy;
      s2_ty_r    <= s1_ty_r;
    end
  end

  always_comb begin
    for (int k = 0; k < bilin_pkg::NUM_CHAN; k++) begin
      sum[k] = SUMX_W'(top_r[k]) * SUMX_W'(s2_uy_r) +
               SUMX_W'(bot_r[k]) * SUMX_W'(s2_ty_r) + RND;
      res_nxt[k] = s2_empty_r ? '0 : sum[k][SHIFT +: bilin_pkg::CHAN_W];
    end
    out_valid_nxt = adv ? s2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= pop_valid && !pop_entry.is_write;
        s2_valid_r <= s1_valid_r;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = res_r[0];
  assign out_green = res_r[1];
  assign out_blue  = res_r[2];
  assign out_alpha = res_r[3];

endmodule

### rtl/bilinear_rgba_sampler.sv
// top level of the bilinear rgba sampler with clamp-to-edge addressing
// Takes one transaction per clock while out_ready stays high, texel write or sample, and returns
// one rgba result per sample after it passes the input register, queue, store read, horizontal
// blend and vertical blend into the output register. The texel store is split into four banks
// by row and column parity, so the four neighbours of a sample are read together, one from each
// bank; that single read per bank and the two multiply stages set the rate of one item per
// clock. Writes and samples pass through the store in order, so a sample always sees every
// write accepted before it. Writes give no result. Stored texels are undefined until written.
// Image width and height are written through the cfg port while no transaction is in
// flight; a zero width or height makes every sample return zero.
module bilinear_rgba_sampler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bilin_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bilin_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [bilin_pkg::IN_COL_W-1:0]       in_texel_col,
  input  logic [bilin_pkg::IN_ROW_W-1:0]       in_texel_row,
  input  logic [bilin_pkg::CHAN_W-1:0]         in_write_red,
  input  logic [bilin_pkg::CHAN_W-1:0]         in_write_green,
  input  logic [bilin_pkg::CHAN_W-1:0]         in_write_blue,
  input  logic [bilin_pkg::CHAN_W-1:0]         in_write_alpha,
  input  logic signed [bilin_pkg::COORD_W-1:0] in_sample_x,
  input  logic signed [bilin_pkg::COORD_W-1:0] in_sample_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bilin_pkg::CHAN_W-1:0]         out_red,
  output logic [bilin_pkg::CHAN_W-1:0]         out_green,
  output logic [bilin_pkg::CHAN_W-1:0]         out_blue,
  output logic [bilin_pkg::CHAN_W-1:0]         out_alpha
);

  logic             push_valid, push_ready;
  bilin_pkg::qent_t push_entry;
  logic             pop_valid, pop_ready;
  bilin_pkg::qent_t pop_entry;

  bilin_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_texel_col   (in_texel_col),
    .in_texel_row   (in_texel_row),
    .in_write_red   (in_write_red),
    .in_write_green (in_write_green),
    .in_write_blue  (in_write_blue),
    .in_write_alpha (in_write_alpha),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_entry     (push_entry)
  );

  bilin_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  bilin_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

endmodule
